### sv/dds_tone_generator_dac_defines.svh
// Assertion macros shared by the tone generator RTL.
`ifndef DDS_TONE_GENERATOR_DAC_DEFINES_SVH
`define DDS_TONE_GENERATOR_DAC_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DDS_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("dds: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define DDS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("dds: next-cycle check failed");

`endif

### sv/dds_pkg.sv
// Shared widths, constants and opcode codes of the tone generator.
package dds_pkg;

    localparam int OPCODE_W = 2;
    localparam int STEP_W   = 24;
    localparam int LEVEL_W  = 16;
    localparam int DAC_W    = 16;
    localparam int AMP_SHIFT = 16;

    localparam int DEFAULT_TABLE_ENTRIES = 256;
    localparam int DEFAULT_FRACTION_BITS = 16;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK      = 2'd0,
        OP_SET_STEP  = 2'd1,
        OP_SET_LEVEL = 2'd2
    } opcode_t;

endpackage

### sv/dds_in_if.sv
// Command channel of the tone generator: valid, ready and one command beat.
interface dds_in_if;
    import dds_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [STEP_W-1:0]   step_value;
    logic [LEVEL_W-1:0]  level_value;

    modport source (output valid, output opcode, output step_value, output level_value,
                    input ready);
    modport sink   (input valid, input opcode, input step_value, input level_value,
                    output ready);
endinterface

### sv/dds_out_if.sv
// Sample channel of the tone generator: valid, ready and one DAC beat.
interface dds_out_if;
    import dds_pkg::*;

    logic             valid;
    logic             ready;
    logic [DAC_W-1:0] dac_value;
    logic             tone_active;

    modport source (output valid, output dac_value, output tone_active, input ready);
    modport sink   (input valid, input dac_value, input tone_active, output ready);
endinterface

### sv/dds_tone_generator_dac.sv
// DDS tone generator: phase accumulator, sine table and amplitude scaling for a DAC.
//
// Usage:
//   cmd carries command beats (opcode, step_value, level_value); sample carries
//   DAC beats (dac_value, tone_active). Both use valid/ready; a beat moves on a
//   rising edge with valid and ready high.
//   A tick with a running tone and a set-level while idle each yield one sample
//   beat; every other command yields none.
//   A command passes the input register, then the result register.
//   Throughput: one command per cycle unless sample stalls. Phase add, wrap
//   reduction, table read and the 16x16 amplitude multiply all sit between the
//   input and result registers.
//   Stall: while sample is stalled the result register holds; one more command
//   waits in the input register, then cmd.ready drops.
//   Reset: phase, step, amplitudes and run request clear; both registers empty.
`include "dds_tone_generator_dac_defines.svh"

module dds_tone_generator_dac #(
    parameter int TABLE_ENTRIES = dds_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int FRACTION_BITS = dds_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    dds_in_if.sink    cmd,
    dds_out_if.source sample
);
    import dds_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int PHASE_W = IDX_W + FRACTION_BITS;
    localparam int SUM_W   = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
    localparam int X_W     = SUM_W - FRACTION_BITS;
    localparam int RECIP   = (1 << X_W) / TABLE_ENTRIES;
    localparam logic [SUM_W-1:0] PERIOD = SUM_W'(TABLE_ENTRIES) << FRACTION_BITS;
    localparam logic [X_W-1:0]   T_X    = X_W'(TABLE_ENTRIES);

    typedef logic [DAC_W-1:0] rom_t [TABLE_ENTRIES];

    function automatic longint unsigned quarter_sine(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        x  = (HALF_PI_Q30 * r) / TABLE_ENTRIES;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        t  = ((t * x2) >> 30) / 6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 110;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 156;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 210;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 272;
        s  = s + longint'(t);
        if (s < 0)
        begin
            s = 0;
        end
        if (s > longint'(ONE_Q30))
        begin
            s = longint'(ONE_Q30);
        end
        return longint'(unsigned'(s));
    endfunction

    function automatic rom_t build_rom();
        rom_t            rom;
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned s;
        longint unsigned mag;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            q4   = longint'(i) * 4;
            quad = q4 / TABLE_ENTRIES;
            r    = q4 % TABLE_ENTRIES;
            if ((quad & 64'd1) != 0)
            begin
                r = TABLE_ENTRIES - r;
            end
            s   = quarter_sine(r);
            mag = (64'd32767 * s + (ONE_Q30 >> 1)) >> 30;
            if ((quad & 64'd2) != 0)
            begin
                rom[i] = DAC_W'(64'd32768 - mag);
            end
            else
            begin
                rom[i] = DAC_W'(64'd32768 + mag);
            end
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic                 in_valid_reg;
    opcode_t              op_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [LEVEL_W-1:0]   level_reg;

    logic [PHASE_W-1:0]   phase_acc_reg, phase_acc_next;
    logic [STEP_W-1:0]    phase_inc_reg, phase_inc_next;
    logic [DAC_W-1:0]     live_amp_reg, live_amp_next;
    logic [LEVEL_W-1:0]   pend_amp_reg, pend_amp_next;
    logic                 run_req_reg, run_req_next;

    logic                 out_valid_reg;
    logic [DAC_W-1:0]     dac_reg, dac_next;
    logic                 active_reg, active_next;
    logic                 produce;

    logic                 out_free;
    logic                 fire;
    logic                 idle;
    logic [DAC_W-1:0]     rom_word;
    logic [2*DAC_W-1:0]   scaled;
    logic [DAC_W-1:0]     sample_word;
    logic [SUM_W-1:0]     phase_sum;
    logic [SUM_W-1:0]     phase_ext;
    logic                 wrap;
    logic [X_W-1:0]       sum_hi;
    logic [2*X_W-1:0]     quot_prod;
    logic [X_W-1:0]       quot;
    logic [X_W-1:0]       rem_prod;
    logic [X_W-1:0]       rem_est;
    logic [X_W-1:0]       rem;
    logic [PHASE_W-1:0]   wrapped_phase;
    logic                 stop_now;

    assign out_free  = !out_valid_reg || sample.ready;
    assign fire      = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;

    assign idle        = (phase_inc_reg == '0);
    assign rom_word    = SINE_ROM[phase_acc_reg[PHASE_W-1:FRACTION_BITS]];
    assign scaled      = (2*DAC_W)'(rom_word) * (2*DAC_W)'(live_amp_reg);
    assign sample_word = scaled[AMP_SHIFT +: DAC_W];

    assign phase_ext = SUM_W'(phase_acc_reg);
    assign phase_sum = phase_ext + SUM_W'(phase_inc_reg);
    assign wrap      = (phase_sum >= PERIOD);

    // reduce the integer phase modulo the table length: reciprocal, then one correction
    assign sum_hi    = phase_sum[SUM_W-1:FRACTION_BITS];
    assign quot_prod = (2*X_W)'(sum_hi) * (2*X_W)'(RECIP);
    assign quot      = quot_prod[2*X_W-1:X_W];
    assign rem_prod  = quot * T_X;
    assign rem_est   = sum_hi - rem_prod;
    assign rem       = (rem_est >= T_X) ? (rem_est - T_X) : rem_est;
    assign wrapped_phase = {rem[IDX_W-1:0], phase_sum[FRACTION_BITS-1:0]};

    assign stop_now = fire && (op_reg == OP_TICK) && !idle && wrap && !run_req_reg;

    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        phase_inc_next = phase_inc_reg;
        live_amp_next  = live_amp_reg;
        pend_amp_next  = pend_amp_reg;
        run_req_next   = run_req_reg;
        dac_next       = dac_reg;
        active_next    = active_reg;
        produce        = 1'b0;
        if (fire)
        begin
            unique case (op_reg)
                OP_TICK:
                begin
                    if (!idle)
                    begin
                        produce        = 1'b1;
                        dac_next       = sample_word;
                        phase_acc_next = phase_sum[PHASE_W-1:0];
                        if (wrap)
                        begin
                            phase_acc_next = wrapped_phase;
                            live_amp_next  = pend_amp_reg;
                            if (!run_req_reg)
                            begin
                                phase_inc_next = '0;
                                phase_acc_next = '0;
                            end
                        end
                        active_next = (phase_inc_next != '0);
                    end
                end
                OP_SET_STEP:
                begin
                    if (step_reg != '0)
                    begin
                        run_req_next   = 1'b1;
                        phase_inc_next = step_reg;
                    end
                    else
                    begin
                        run_req_next = 1'b0;
                    end
                end
                OP_SET_LEVEL:
                begin
                    pend_amp_next = level_reg;
                    if (idle)
                    begin
                        live_amp_next = level_reg;
                        produce       = 1'b1;
                        dac_next      = level_reg;
                        active_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_acc_reg <= '0;
            phase_inc_reg <= '0;
            live_amp_reg  <= '0;
            pend_amp_reg  <= '0;
            run_req_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            phase_acc_reg <= phase_acc_next;
            phase_inc_reg <= phase_inc_next;
            live_amp_reg  <= live_amp_next;
            pend_amp_reg  <= pend_amp_next;
            run_req_reg   <= run_req_next;
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sample.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg    <= opcode_t'(cmd.opcode);
            step_reg  <= cmd.step_value;
            level_reg <= cmd.level_value;
        end
        if (produce)
        begin
            dac_reg    <= dac_next;
            active_reg <= active_next;
        end
    end

    assign sample.valid       = out_valid_reg;
    assign sample.dac_value   = dac_reg;
    assign sample.tone_active = active_reg;

    `DDS_ASSERT_IMPL(a_phase_below_period, clk, rst_n, 1'b1, phase_ext < PERIOD)
    `DDS_ASSERT_IMPL(a_idle_phase_zero, clk, rst_n, phase_inc_reg == '0, phase_acc_reg == '0)
    `DDS_ASSERT_NEXT(a_stop_at_wrap, clk, rst_n, stop_now, phase_inc_reg == '0)
    `DDS_ASSERT_NEXT(a_amp_hold, clk, rst_n, !fire, $stable(live_amp_reg))

endmodule
